FILE: rtl/core/wsp_pkg.sv
// shared types, codes and header layout for the wav stream parser
package wsp_pkg;

  localparam int MAX_SAMPLE_BYTES = 4;

  typedef enum logic [1:0] {
    KIND_HDR    = 2'd0,
    KIND_SAMPLE = 2'd1,
    KIND_ERR    = 2'd2
  } kind_t;

  typedef enum logic {
    ERR_FORMAT = 1'b0,
    ERR_WIDTH  = 1'b1
  } err_t;

  typedef enum logic [2:0] {
    PH_HEADER = 3'b001,
    PH_DATA   = 3'b010,
    PH_IDLE   = 3'b100
  } phase_t;

  localparam logic [3:0] FIELD_FORMAT = 4'd2;
  localparam logic [3:0] FIELD_BITS   = 4'd10;
  localparam logic [3:0] FIELD_DSIZE  = 4'd12;

  typedef struct packed {
    kind_t              kind;
    logic [3:0]         field_index;
    logic [31:0]        header_value;
    logic signed [31:0] sample_value;
    err_t               error_code;
    logic               last;
  } res_t;

  typedef struct packed {
    logic [3:0] idx;
    logic [5:0] first;
    logic [5:0] end_pos;
  } fld_t;

  // header byte position to field number and byte span
  function automatic fld_t fld_info(input logic [5:0] pos);
    fld_t f;
    case (pos) inside
      [6'd0:6'd3]:   f = '{4'd0,  6'd0,  6'd3};
      [6'd4:6'd7]:   f = '{4'd1,  6'd4,  6'd7};
      [6'd8:6'd11]:  f = '{4'd2,  6'd8,  6'd11};
      [6'd12:6'd15]: f = '{4'd3,  6'd12, 6'd15};
      [6'd16:6'd19]: f = '{4'd4,  6'd16, 6'd19};
      [6'd20:6'd21]: f = '{4'd5,  6'd20, 6'd21};
      [6'd22:6'd23]: f = '{4'd6,  6'd22, 6'd23};
      [6'd24:6'd27]: f = '{4'd7,  6'd24, 6'd27};
      [6'd28:6'd31]: f = '{4'd8,  6'd28, 6'd31};
      [6'd32:6'd33]: f = '{4'd9,  6'd32, 6'd33};
      [6'd34:6'd35]: f = '{4'd10, 6'd34, 6'd35};
      [6'd36:6'd39]: f = '{4'd11, 6'd36, 6'd39};
      default:       f = '{4'd12, 6'd40, 6'd43};
    endcase
    return f;
  endfunction

  // ids are big-endian packed four-byte tags
  function automatic logic fld_is_id(input logic [3:0] idx);
    return (idx == 4'd0) || (idx == 4'd2) || (idx == 4'd3) || (idx == 4'd11);
  endfunction

  function automatic logic [7:0] wave_byte(input logic [1:0] off);
    logic [7:0] c;
    case (off)
      2'd0:    c = 8'h57;  // W
      2'd1:    c = 8'h41;  // A
      2'd2:    c = 8'h56;  // V
      default: c = 8'h45;  // E
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/core/wsp_if.sv
// stream channel interfaces for bytes in and parsed results out
interface wsp_in_if;
  logic       valid;
  logic       ready;
  logic       start_of_file;
  logic [7:0] data_byte;

  modport source (output valid, start_of_file, data_byte, input ready);
  modport sink   (input valid, start_of_file, data_byte, output ready);
endinterface

interface wsp_out_if;
  logic               valid;
  logic               ready;
  wsp_pkg::kind_t     kind;
  logic [3:0]         field_index;
  logic [31:0]        header_value;
  logic signed [31:0] sample_value;
  wsp_pkg::err_t      error_code;
  logic               last;

  modport source (output valid, kind, field_index, header_value, sample_value,
                  error_code, last, input ready);
  modport sink   (input valid, kind, field_index, header_value, sample_value,
                  error_code, last, output ready);
endinterface

FILE: rtl/core/wsp_in_reg.sv
// input register stage holding one byte request
module wsp_in_reg (
  input  logic       clk,
  input  logic       rst_n,
  wsp_in_if.sink     in_ch,
  input  logic       advance,
  output logic       item_valid,
  output logic       item_sof,
  output logic [7:0] item_byte
);

  logic       valid_r, valid_nxt;
  logic       sof_r;
  logic [7:0] byte_r;
  logic       take;

  assign in_ch.ready = !valid_r || advance;
  assign take        = in_ch.valid && in_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      sof_r  <= in_ch.start_of_file;
      byte_r <= in_ch.data_byte;
    end
  end

  assign item_valid = valid_r;
  assign item_sof   = sof_r;
  assign item_byte  = byte_r;

endmodule

FILE: rtl/core/wsp_parser.sv
// header field and sample assembly, one byte per strobe
module wsp_parser (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step,
  input  logic          sof,
  input  logic [7:0]    data_byte,
  output logic          res_valid,
  output wsp_pkg::res_t res
);
  import wsp_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [5:0]  hcnt_r, hcnt_nxt;
  logic [31:0] facc_r, facc_nxt;
  logic        tag_ok_r, tag_ok_nxt;
  logic [2:0]  sw_r, sw_nxt;
  logic [31:0] left_r, left_nxt;
  logic [1:0]  sidx_r, sidx_nxt;
  logic [31:0] sacc_r, sacc_nxt;

  phase_t      ph;
  fld_t        fi;
  logic [1:0]  off;
  logic [31:0] acc_new;
  logic        tag_new;
  logic [12:0] wbytes;
  logic [31:0] sacc_new;
  logic [31:0] left_new;
  logic [31:0] sval;

  always_comb begin
    // start flag clears everything before this byte is taken
    ph         = sof ? PH_HEADER : phase_r;
    phase_nxt  = ph;
    hcnt_nxt   = sof ? 6'd0 : hcnt_r;
    facc_nxt   = sof ? 32'd0 : facc_r;
    tag_ok_nxt = sof ? 1'b1 : tag_ok_r;
    sw_nxt     = sof ? 3'd0 : sw_r;
    left_nxt   = sof ? 32'd0 : left_r;
    sidx_nxt   = sof ? 2'd0 : sidx_r;
    sacc_nxt   = sof ? 32'd0 : sacc_r;

    fi       = fld_info(hcnt_nxt);
    off      = hcnt_nxt[1:0] - fi.first[1:0];
    acc_new  = fld_is_id(fi.idx) ? {facc_nxt[23:0], data_byte}
                                 : facc_nxt | ({24'd0, data_byte} << {off, 3'b000});
    tag_new  = tag_ok_nxt && !((fi.idx == FIELD_FORMAT) && (data_byte != wave_byte(off)));
    wbytes   = acc_new[15:3];
    sacc_new = sacc_nxt | ({24'd0, data_byte} << {sidx_nxt, 3'b000});
    left_new = left_nxt - 32'd1;
    sval     = sacc_new;
    if ((sw_nxt == 3'd2) && sacc_new[15]) begin
      sval = {16'hFFFF, sacc_new[15:0]};
    end

    res_valid        = 1'b0;
    res.kind         = KIND_HDR;
    res.field_index  = fi.idx;
    res.header_value = acc_new;
    res.sample_value = '0;
    res.error_code   = ERR_FORMAT;
    res.last         = 1'b0;

    case (ph)
      PH_HEADER: begin
        tag_ok_nxt = tag_new;
        facc_nxt   = acc_new;
        if (hcnt_nxt == fi.end_pos) begin
          facc_nxt  = 32'd0;
          res_valid = 1'b1;
          if ((fi.idx == FIELD_FORMAT) && !tag_new) begin
            phase_nxt = PH_IDLE;
            res.kind  = KIND_ERR;
          end else if (fi.idx == FIELD_BITS) begin
            sw_nxt = ((wbytes >= 13'd1) && (wbytes <= 13'(MAX_SAMPLE_BYTES)))
                     ? wbytes[2:0] : 3'd0;
          end else if (fi.idx == FIELD_DSIZE) begin
            if (sw_nxt == 3'd0) begin
              phase_nxt      = PH_IDLE;
              res.kind       = KIND_ERR;
              res.error_code = ERR_WIDTH;
            end else begin
              left_nxt  = acc_new;
              sidx_nxt  = 2'd0;
              sacc_nxt  = 32'd0;
              phase_nxt = (acc_new != 32'd0) ? PH_DATA : PH_IDLE;
            end
          end
        end
        hcnt_nxt = hcnt_nxt + 6'd1;
      end
      PH_DATA: begin
        left_nxt = left_new;
        if (({1'b0, sidx_nxt} + 3'd1) == sw_nxt) begin
          res_valid        = 1'b1;
          res.kind         = KIND_SAMPLE;
          res.field_index  = 4'd0;
          res.header_value = 32'd0;
          res.sample_value = sval;
          res.last         = (left_new < {29'd0, sw_nxt});
          sidx_nxt         = 2'd0;
          sacc_nxt         = 32'd0;
        end else begin
          sidx_nxt = sidx_nxt + 2'd1;
          sacc_nxt = sacc_new;
        end
        if (left_new == 32'd0) begin
          phase_nxt = PH_IDLE;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HEADER;
      hcnt_r   <= 6'd0;
      facc_r   <= 32'd0;
      tag_ok_r <= 1'b1;
      sw_r     <= 3'd0;
      left_r   <= 32'd0;
      sidx_r   <= 2'd0;
      sacc_r   <= 32'd0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      hcnt_r   <= hcnt_nxt;
      facc_r   <= facc_nxt;
      tag_ok_r <= tag_ok_nxt;
      sw_r     <= sw_nxt;
      left_r   <= left_nxt;
      sidx_r   <= sidx_nxt;
      sacc_r   <= sacc_nxt;
    end
  end

  a_sample_in_data: assert property (@(posedge clk) disable iff (!rst_n)
    step && res_valid && (res.kind == KIND_SAMPLE) |-> !sof && (phase_r == PH_DATA))
    else $error("sample produced outside data phase");

  a_fmt_err_field: assert property (@(posedge clk) disable iff (!rst_n)
    step && res_valid && (res.kind == KIND_ERR) && (res.error_code == ERR_FORMAT)
    |-> res.field_index == FIELD_FORMAT)
    else $error("format error raised on wrong field");

  a_width_valid: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DATA |-> (sw_r != 3'd0) && (sw_r <= 3'(MAX_SAMPLE_BYTES)))
    else $error("data phase with unsupported sample width");

endmodule

FILE: rtl/core/wav_stream_parser_core.sv
// top level: byte input register, parser, and result register
// Parses a canonical 44-byte WAV header from a byte stream and then assembles
// its PCM samples. One byte is taken per cycle with no bubbles while results
// are read: each byte passes through an input register, one stage of parse
// logic and a result register, which holds each result until it is read.
// The input stalls only while a result waits unread and the input register
// already holds a byte. Each header field is emitted on its last byte (ids
// big-endian, numbers little-endian); a format tag other than WAVE or a sample
// width outside 1..4 bytes gives an error and the rest of the file is dropped
// until the next start flag. The final full sample carries last; a trailing
// partial sample is consumed silently.
module wav_stream_parser_core (
  input  logic     clk,
  input  logic     rst_n,
  wsp_in_if.sink   in_ch,
  wsp_out_if.source out_ch
);
  import wsp_pkg::*;

  logic       item_valid;
  logic       item_sof;
  logic [7:0] item_byte;
  logic       step;
  logic       res_valid;
  res_t       res;

  logic       out_valid_r, out_valid_nxt;
  res_t       out_r;

  // a byte moves on whenever the result slot is free or being emptied
  assign step = item_valid && (!out_valid_r || out_ch.ready);

  wsp_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .advance    (step),
    .item_valid (item_valid),
    .item_sof   (item_sof),
    .item_byte  (item_byte)
  );

  wsp_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .sof       (item_sof),
    .data_byte (item_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ch.ready;
    if (step) begin
      out_valid_nxt = res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_valid) begin
      out_r <= res;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.kind         = out_r.kind;
  assign out_ch.field_index  = out_r.field_index;
  assign out_ch.header_value = out_r.header_value;
  assign out_ch.sample_value = out_r.sample_value;
  assign out_ch.error_code   = out_r.error_code;
  assign out_ch.last         = out_r.last;

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |=> out_valid_r)
    else $error("pending result lost");

  a_step_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    step |-> !out_valid_r || out_ch.ready)
    else $error("parser advanced into a full result slot");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |=> $stable(out_r))
    else $error("waiting result changed");

endmodule
